[hw/rtl/dro_pkg.sv]
package dro_pkg;

    // Field widths
    localparam int CNT_W       = 32;
    localparam int ANGLE_W     = 16;
    localparam int SCALE_W     = 20;
    localparam int ARENA_W     = 16;
    localparam int HEAD_W      = 17;
    localparam int POS_W       = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 120;
    localparam int OUT_PAD_W   = OUT_DATA_W - (2 * POS_W + HEAD_W + 1);

    // |dR + dL| and the scaled distance magnitude
    localparam int SUM_W       = CNT_W + 1;
    localparam int DMAG_W      = SUM_W + SCALE_W;

    localparam int SINE_FRAC_BITS_DEF = 15;
    localparam int SINE_LAST          = 90;

    // Heading modulo 360 by restoring subtraction
    localparam int MOD_W                = 18;
    localparam int MOD_STEPS            = 9;
    localparam logic [MOD_W-1:0] MOD_OFFSET  = 18'd65880;  // 183 * 360
    localparam logic [MOD_W-1:0] MOD_DIV_TOP = 18'd92160;  // 360 << 8
    localparam logic [MOD_W-1:0] MOD_DEG     = 18'd360;

    localparam logic [SCALE_W-1:0]       DIST_SCALE_RST = 20'd16012;
    localparam logic [ARENA_W-1:0]       ARENA_MAX_RST  = 16'hFFFF;
    localparam logic signed [HEAD_W-1:0] HEAD_RST       = 17'sd90;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIST_SCALE  = 2'd0,
        CFG_ARENA_MAX_X = 2'd1,
        CFG_ARENA_MAX_Y = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIST,
        S_TRIG,
        S_STEP,
        S_RND,
        S_ACC,
        S_OUT
    } t_state;

    typedef logic [31:0] t_sine_rom [SINE_LAST+1];

    localparam longint unsigned PI_Q30   = 64'd3373259426;
    localparam longint unsigned Q30_HALF = 64'd536870912;
    localparam longint          Q30_ONE  = 64'sd1073741824;

    function automatic longint unsigned mul_q30(input longint unsigned a,
                                                input longint unsigned b);
        return (a * b + Q30_HALF) >> 30;
    endfunction

    // divide a Taylor term by (2n)(2n+1)
    function automatic longint unsigned taylor_div(input longint unsigned v, input int n);
        case (n)
            1:       return v / 64'd6;
            2:       return v / 64'd20;
            3:       return v / 64'd42;
            4:       return v / 64'd72;
            5:       return v / 64'd110;
            6:       return v / 64'd156;
            7:       return v / 64'd210;
            default: return v / 64'd272;
        endcase
    endfunction

    // Quarter-wave sine in Q1.frac, Taylor series through x^17 in Q30
    function automatic t_sine_rom sine_rom_build(input int frac);
        t_sine_rom         rom;
        longint unsigned   x;
        longint unsigned   term;
        longint unsigned   rnd;
        longint            sum;
        for (int k = 0; k <= SINE_LAST; k++) begin
            x    = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = taylor_div(mul_q30(mul_q30(term, x), x), n);
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > Q30_ONE) begin
                sum = Q30_ONE;
            end
            rnd    = 64'd1 << (29 - frac);
            rom[k] = 32'((longint'(sum) + longint'(rnd)) >>> (30 - frac));
        end
        return rom;
    endfunction

endpackage

[hw/rtl/dead_reckoning_odometry.sv]
// Differential-drive odometry with gyro heading. Each input transfer is one update tick
// carrying absolute right/left encoder counts and the absolute gyro angle; each tick yields
// exactly one result with the saturated Q31.16 x/y position, the unwrapped heading (reset 90)
// and an inside-arena flag. The summed wheel delta is scaled by distance_scale, then x and y
// advance by distance times cosine and sine of the heading taken from a quarter-wave table.
// Both products run on bit-serial shift-and-add multipliers, so an item occupies the block
// while the distance scale and then the sine/cosine products (x and y in parallel) run,
// plus handshake and fixed-up stages. A new tick is taken as soon as the previous one has
// moved into the output register, even if that result is still waiting. Position and
// heading are cleared only by reset; write configuration only while the block is idle.
module dead_reckoning_odometry import dro_pkg::*; #(
    parameter int SINE_FRAC_BITS = SINE_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [31:0] right_count, [63:32] left_count, [79:64] gyro_angle
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [47:0] pos_x, [95:48] pos_y, [112:96] heading_deg, [113] inside_arena, rest zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SCALE_W-1:0]    i_cfg_data
);

    localparam int SIN_W     = SINE_FRAC_BITS + 1;
    localparam int STEP_PW   = DMAG_W + SIN_W;
    localparam int STEP_W    = DMAG_W + 1;
    localparam int ACC_SUM_W = STEP_W + 1;
    localparam int HSUM_W    = HEAD_W + 2;

    localparam t_sine_rom SINE_ROM = sine_rom_build(SINE_FRAC_BITS);
    localparam logic [SIN_W-1:0]   SIN_ONE  = SIN_W'(1) << SINE_FRAC_BITS;
    localparam logic [STEP_PW:0]   RND_HALF = (STEP_PW + 1)'(1) << (SINE_FRAC_BITS - 1);

    localparam logic [8:0] DEG_90  = 9'd90;
    localparam logic [8:0] DEG_180 = 9'd180;
    localparam logic [8:0] DEG_270 = 9'd270;
    localparam logic [8:0] DEG_360 = 9'd360;

    localparam logic signed [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [HEAD_W-1:0] HEAD_MAX = {1'b0, {(HEAD_W-1){1'b1}}};
    localparam logic signed [HEAD_W-1:0] HEAD_MIN = {1'b1, {(HEAD_W-1){1'b0}}};

    t_state r_state;
    t_state n_state;

    // configuration
    logic [SCALE_W-1:0] r_scale;
    logic [ARENA_W-1:0] r_max_x;
    logic [ARENA_W-1:0] r_max_y;

    // state carried across ticks
    logic [CNT_W-1:0]          r_last_r;
    logic [CNT_W-1:0]          r_last_l;
    logic signed [ANGLE_W-1:0] r_last_g;
    logic signed [HEAD_W-1:0]  r_head;
    logic signed [POS_W-1:0]   r_acc_x;
    logic signed [POS_W-1:0]   r_acc_y;

    // per-tick working registers
    logic [CNT_W-1:0]         r_dr;
    logic [CNT_W-1:0]         r_dl;
    logic [SUM_W-1:0]         r_sum_mag;
    logic                     r_sum_neg;
    logic [MOD_W-1:0]         r_mod;
    logic [MOD_W-1:0]         r_div;
    logic [3:0]               r_cnt;
    logic [SIN_W-1:0]         r_sin_mag;
    logic [SIN_W-1:0]         r_cos_mag;
    logic                     r_sin_neg;
    logic                     r_cos_neg;
    logic signed [STEP_W-1:0] r_step_x;
    logic signed [STEP_W-1:0] r_step_y;
    logic                     r_go;

    // output register
    logic                     r_out_valid;
    logic [POS_W-1:0]         r_out_x;
    logic [POS_W-1:0]         r_out_y;
    logic [HEAD_W-1:0]        r_out_head;
    logic                     r_out_inside;

    logic                      w_accept;
    logic                      w_out_free;
    logic                      w_out_load;
    logic [CNT_W-1:0]          w_in_r;
    logic [CNT_W-1:0]          w_in_l;
    logic signed [ANGLE_W-1:0] w_in_g;
    logic signed [HSUM_W-1:0]  w_head_sum;
    logic signed [HEAD_W-1:0]  w_head_sat;
    logic signed [SUM_W-1:0]   w_wsum;
    logic [8:0]                w_m_sin;
    logic [8:0]                w_m_cos_raw;
    logic [8:0]                w_m_cos;
    logic [7:0]                w_fold_sin;
    logic [7:0]                w_fold_cos;
    logic                      w_dist_done;
    logic [DMAG_W-1:0]         w_dist_prod;
    logic                      w_step_done_x;
    logic                      w_step_done_y;
    logic [STEP_PW-1:0]        w_prod_x;
    logic [STEP_PW-1:0]        w_prod_y;
    logic [STEP_PW:0]          w_rnd_x;
    logic [STEP_PW:0]          w_rnd_y;
    logic [DMAG_W-1:0]         w_mag_x;
    logic [DMAG_W-1:0]         w_mag_y;
    logic                      w_neg_x;
    logic                      w_neg_y;
    logic signed [ACC_SUM_W-1:0] w_acc_sum_x;
    logic signed [ACC_SUM_W-1:0] w_acc_sum_y;
    logic                      w_inside;

    // fold an angle in 0..359 onto the quarter-wave table: {negate, index}
    function automatic logic [7:0] quad_fold(input logic [8:0] m);
        logic [8:0] idx;
        logic       neg;
        if (m < DEG_90) begin
            idx = m;
            neg = 1'b0;
        end else if (m < DEG_180) begin
            idx = DEG_180 - m;
            neg = 1'b0;
        end else if (m < DEG_270) begin
            idx = m - DEG_180;
            neg = 1'b1;
        end else begin
            idx = DEG_360 - m;
            neg = 1'b1;
        end
        return {neg, idx[6:0]};
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(
        input logic signed [ACC_SUM_W-1:0] v
    );
        logic [ACC_SUM_W-POS_W:0] top;
        top = v[ACC_SUM_W-1:POS_W-1];
        if (&top || ~|top) begin
            return v[POS_W-1:0];
        end else if (v[ACC_SUM_W-1]) begin
            return POS_MIN;
        end else begin
            return POS_MAX;
        end
    endfunction

    assign w_in_r = i_s_tdata[31:0];
    assign w_in_l = i_s_tdata[63:32];
    assign w_in_g = i_s_tdata[79:64];

    assign w_head_sum = HSUM_W'(r_head) + HSUM_W'(r_last_g) - HSUM_W'(w_in_g);
    always_comb begin
        if (w_head_sum > HSUM_W'(HEAD_MAX)) begin
            w_head_sat = HEAD_MAX;
        end else if (w_head_sum < HSUM_W'(HEAD_MIN)) begin
            w_head_sat = HEAD_MIN;
        end else begin
            w_head_sat = w_head_sum[HEAD_W-1:0];
        end
    end

    assign w_wsum = SUM_W'($signed(r_dr)) + SUM_W'($signed(r_dl));

    assign w_m_sin     = r_mod[8:0];
    assign w_m_cos_raw = w_m_sin + DEG_90;
    assign w_m_cos     = (w_m_cos_raw >= DEG_360) ? (w_m_cos_raw - DEG_360) : w_m_cos_raw;
    assign w_fold_sin  = quad_fold(w_m_sin);
    assign w_fold_cos  = quad_fold(w_m_cos);

    assign w_rnd_x = {1'b0, w_prod_x} + RND_HALF;
    assign w_rnd_y = {1'b0, w_prod_y} + RND_HALF;
    assign w_mag_x = w_rnd_x[SINE_FRAC_BITS +: DMAG_W];
    assign w_mag_y = w_rnd_y[SINE_FRAC_BITS +: DMAG_W];
    assign w_neg_x = r_sum_neg ^ r_cos_neg;
    assign w_neg_y = r_sum_neg ^ r_sin_neg;

    assign w_acc_sum_x = ACC_SUM_W'(r_acc_x) + ACC_SUM_W'(r_step_x);
    assign w_acc_sum_y = ACC_SUM_W'(r_acc_y) + ACC_SUM_W'(r_step_y);

    // floor(x) <= max_x, negative positions count as inside
    assign w_inside = ($signed({r_acc_x[POS_W-1], r_acc_x[POS_W-1:16]})
                       <= $signed({17'd0, r_max_x}))
                   && ($signed({r_acc_y[POS_W-1], r_acc_y[POS_W-1:16]})
                       <= $signed({17'd0, r_max_y}));

    dro_sermul #(
        .A_W (SUM_W),
        .B_W (SCALE_W)
    ) u_dist_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && r_state == S_DIST),
        .i_a     (r_sum_mag),
        .i_b     (r_scale),
        .o_done  (w_dist_done),
        .o_prod  (w_dist_prod)
    );

    dro_sermul #(
        .A_W (DMAG_W),
        .B_W (SIN_W)
    ) u_x_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && r_state == S_STEP),
        .i_a     (w_dist_prod),
        .i_b     (r_cos_mag),
        .o_done  (w_step_done_x),
        .o_prod  (w_prod_x)
    );

    dro_sermul #(
        .A_W (DMAG_W),
        .B_W (SIN_W)
    ) u_y_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && r_state == S_STEP),
        .i_a     (w_dist_prod),
        .i_b     (r_sin_mag),
        .o_done  (w_step_done_y),
        .o_prod  (w_prod_y)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_s_tvalid)    n_state = S_PREP;
            S_PREP:                    n_state = S_DIST;
            S_DIST: if (w_dist_done)   n_state = S_TRIG;
            S_TRIG:                    n_state = S_STEP;
            S_STEP: if (w_step_done_x) n_state = S_RND;
            S_RND:                     n_state = S_ACC;
            S_ACC:                     n_state = S_OUT;
            S_OUT:  if (w_out_free)    n_state = S_IDLE;
            default:                   n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE:  o_s_tready = 1'b1;
            S_OUT:   w_out_load = w_out_free;
            default: begin
                o_s_tready = 1'b0;
                w_out_load = 1'b0;
            end
        endcase
    end

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            r_scale     <= DIST_SCALE_RST;
            r_max_x     <= ARENA_MAX_RST;
            r_max_y     <= ARENA_MAX_RST;
            r_last_r    <= '0;
            r_last_l    <= '0;
            r_last_g    <= '0;
            r_head      <= HEAD_RST;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
        end else begin
            r_state <= n_state;
            r_go    <= (r_state == S_PREP) || (r_state == S_TRIG);

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_DIST_SCALE:  r_scale <= i_cfg_data;
                    CFG_ARENA_MAX_X: r_max_x <= i_cfg_data[ARENA_W-1:0];
                    CFG_ARENA_MAX_Y: r_max_y <= i_cfg_data[ARENA_W-1:0];
                    default: ;  // drop writes beyond the register list
                endcase
            end

            if (w_accept) begin
                r_last_r <= w_in_r;
                r_last_l <= w_in_l;
                r_last_g <= w_in_g;
                r_head   <= w_head_sat;
            end

            if (r_state == S_ACC) begin
                r_acc_x <= sat_pos(w_acc_sum_x);
                r_acc_y <= sat_pos(w_acc_sum_y);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dr <= w_in_r - r_last_r;
            r_dl <= w_in_l - r_last_l;
        end

        if (r_state == S_PREP) begin
            r_sum_neg <= w_wsum[SUM_W-1];
            r_sum_mag <= w_wsum[SUM_W-1] ? SUM_W'(-w_wsum) : SUM_W'(w_wsum);
            r_mod     <= MOD_W'(r_head) + MOD_OFFSET;
            r_div     <= MOD_DIV_TOP;
            r_cnt     <= '0;
        end

        // one restoring step of heading mod 360 per cycle
        if (r_state == S_DIST && r_cnt < 4'(MOD_STEPS)) begin
            if (r_mod >= r_div) begin
                r_mod <= r_mod - r_div;
            end
            r_div <= r_div >> 1;
            r_cnt <= r_cnt + 4'd1;
        end

        if (r_state == S_TRIG) begin
            r_sin_neg <= w_fold_sin[7];
            r_cos_neg <= w_fold_cos[7];
            r_sin_mag <= SINE_ROM[w_fold_sin[6:0]][SIN_W-1:0];
            r_cos_mag <= SINE_ROM[w_fold_cos[6:0]][SIN_W-1:0];
        end

        if (r_state == S_RND) begin
            r_step_x <= w_neg_x ? -$signed({1'b0, w_mag_x}) : $signed({1'b0, w_mag_x});
            r_step_y <= w_neg_y ? -$signed({1'b0, w_mag_y}) : $signed({1'b0, w_mag_y});
        end

        if (w_out_load) begin
            r_out_x      <= r_acc_x;
            r_out_y      <= r_acc_y;
            r_out_head   <= r_head;
            r_out_inside <= w_inside;
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{OUT_PAD_W{1'b0}}, r_out_inside, r_out_head, r_out_y, r_out_x};
    assign o_cfg_ready = 1'b1;

    a_mod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIG) |-> (r_mod < MOD_DEG))
        else $error("heading reduction unfinished when table is read");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_sin_mag <= SIN_ONE && r_cos_mag <= SIN_ONE))
        else $error("sine magnitude above one");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == S_OUT))
        else $error("result appeared outside the output stage");

    a_xy_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_done_x == w_step_done_y)
        else $error("x and y products out of step");

endmodule

[hw/rtl/dro_sermul.sv]
module dro_sermul #(
    parameter int A_W = 33,
    parameter int B_W = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int CW = $clog2(B_W + 1);

    logic [A_W-1:0] r_a;
    logic [A_W-1:0] r_hi;
    logic [B_W-1:0] r_lo;
    logic [CW-1:0]  r_cnt;
    logic           r_run;
    logic           r_done;
    logic [A_W:0]   w_sum;

    // one multiplier bit a cycle: add, then shift the pair right
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(B_W);
        end else if (r_run) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_run) begin
            r_hi <= w_sum[A_W:1];
            r_lo <= {w_sum[0], r_lo[B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("multiplier done held more than one cycle");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_run && r_cnt == CW'(B_W)))
        else $error("multiplier did not start a full pass");

    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && r_cnt == CW'(1) && !i_start) |=> (r_done && !r_run))
        else $error("multiplier missed its done pulse");

endmodule
